/* design/lrf3d_pkg.sv */
// Shared constants, codes and types for the 3D repulsion force pipeline.
`default_nettype none
package lrf3d_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_WIDTH_DEF = 32;
	localparam int MASS_W        = 32;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int OUT_W         = 48;
	localparam int MUL_W         = 32;
	localparam int NUM_W         = 3 * MASS_W;
	localparam int NUM100_W      = NUM_W + 7;
	localparam int RAD2_W        = CFG_W + 1;

	localparam logic [CFG_W-1:0] COEF_RST    = 32'h0001_0000;
	localparam logic [CFG_W-1:0] RADIUS_RST  = 32'h0001_0000;
	localparam logic [CFG_W-1:0] GRAVITY_RST = 32'h0001_0000;

	localparam logic [OUT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_COEF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANTI    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd3;

	typedef enum logic [1:0] {
		FN_PAIR    = 2'd0,
		FN_REGION  = 2'd1,
		FN_GRAVITY = 2'd2,
		FN_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		MD_NONE,
		MD_SUM,
		MD_QSQ,
		MD_CLOSE,
		MD_GRAV
	} mode_t;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

/* design/layout_repulsion_force_3d.sv */
// Top level: fully pipelined 3D repulsion / gravity force increment unit.
`default_nettype none
// One word in, one word out, one word per cycle sustained unless the result side stalls.
// Four stages form the displacement, the squared distance and the mass product,
// POS_WIDTH + 2 stages take the integer square root one bit each, eight stages build the
// denominator and the wide numerator from 32x32 partial products, 48 stages run a restoring
// divider one quotient bit each, and one stage saturates into the output register. A stall
// on the result side freezes the whole pipeline in place and is passed back as in_stall in
// the same cycle; nothing is dropped. Write registers only while the pipe is empty; the
// block does not enforce it. The force for node B is the negation of the result and is
// left to the caller; applied is low for func 3 and for zero distance, except that
// coincident nodes under anti-collision count as overlapping (radius nonzero) and set it.
module layout_repulsion_force_3d
	import lrf3d_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire  [1:0]                  func,
	input  wire  signed [POS_WIDTH-1:0] a_x,
	input  wire  signed [POS_WIDTH-1:0] a_y,
	input  wire  signed [POS_WIDTH-1:0] a_z,
	input  wire  [MASS_W-1:0]           a_mass,
	input  wire  signed [POS_WIDTH-1:0] b_x,
	input  wire  signed [POS_WIDTH-1:0] b_y,
	input  wire  signed [POS_WIDTH-1:0] b_z,
	input  wire  [MASS_W-1:0]           b_mass,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic signed [OUT_W-1:0]     force_x,
	output logic signed [OUT_W-1:0]     force_y,
	output logic signed [OUT_W-1:0]     force_z,
	output logic                        applied,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [CFG_IDX_W-1:0]        cfg_index,
	input  wire  [CFG_W-1:0]            cfg_data
);

	localparam int FB    = FRAC_BITS;
	localparam int MW    = POS_WIDTH + 1;          // displacement width, signed / magnitude
	localparam int SQW   = 2 * MW;
	localparam int DSW   = SQW + 2;                // sum of three squares
	localparam int RW    = DSW / 2;                // root width
	localparam int REMW  = RW + 2;
	localparam int QW    = max2(RW, RAD2_W) + 1;   // root minus twice the radius, signed
	localparam int QSW   = 2 * RW;
	localparam int NW    = MW + NUM100_W;
	localparam int DENW  = max2(max2(FB + DSW, FB + QSW), max2(2 * FB + RW, 3 * FB + 1));
	localparam int CMPW  = max2(NW - OUT_W, DENW) + 1;
	localparam int DIVN  = OUT_W;
	localparam int PADW  = 2 * MUL_W;
	localparam int NPADW = 4 * MUL_W;
	localparam int ROWW  = NPADW + MUL_W;

	typedef struct packed {
		func_t                func;
		logic [2:0][MW-1:0]   dmag;
		logic [2:0]           dneg;
		logic [NUM_W-1:0]     num;
		logic [DSW-1:0]       dsum;
	} side_t;

	typedef struct packed {
		logic                 hit;
		logic [2:0]           neg;
		logic [2:0]           ovf;
		logic [DENW-1:0]      den;
	} dv_side_t;

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] coef_q, radius_q, gravity_q;
	logic             anti_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= COEF_RST;
			anti_q    <= 1'b0;
			radius_q  <= RADIUS_RST;
			gravity_q <= GRAVITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF:    coef_q    <= cfg_data;
				REG_ANTI:    anti_q    <= cfg_data[0];
				REG_RADIUS:  radius_q  <= cfg_data;
				REG_GRAVITY: gravity_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Whole pipe moves together; held only when the output word is stuck.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------------------------------------------------------- s1: displacement
	logic signed [POS_WIDTH-1:0] pa [3];
	logic signed [POS_WIDTH-1:0] pb [3];
	logic signed [MW-1:0]        dd [3];
	func_t                       func_in;

	assign pa[0] = a_x;
	assign pa[1] = a_y;
	assign pa[2] = a_z;
	assign pb[0] = b_x;
	assign pb[1] = b_y;
	assign pb[2] = b_z;
	assign func_in = func_t'(func);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (func_in == FN_GRAVITY)
				dd[i] = MW'(pa[i]);
			else
				dd[i] = MW'(pa[i]) - MW'(pb[i]);
		end
	end

	logic                  v_s1;
	func_t                 func_s1;
	logic [2:0][MW-1:0]    dmag_s1;
	logic [2:0]            dneg_s1;
	logic [2*MASS_W-1:0]   pc_s1;
	logic [MASS_W-1:0]     mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func_in;
			for (int i = 0; i < 3; i++) begin
				dneg_s1[i] <= dd[i][MW-1];
				dmag_s1[i] <= dd[i][MW-1] ? MW'(-dd[i]) : MW'(dd[i]);
			end
			pc_s1 <= coef_q * a_mass;
			// gravity takes g where pair and region take the partner mass
			mb_s1 <= (func_in == FN_GRAVITY) ? gravity_q : b_mass;
		end
	end

	// ---------------------------------------------------------------- s2: partial products
	logic                  v_s2;
	func_t                 func_s2;
	logic [2:0][MW-1:0]    dmag_s2;
	logic [2:0]            dneg_s2;
	logic [PADW-1:0]       sqpp_s2 [3][3];
	logic [PADW-1:0]       npp_s2 [2];
	logic [PADW-1:0]       dpad1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dpad1[i] = {{(PADW-MW){1'b0}}, dmag_s1[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			dmag_s2 <= dmag_s1;
			dneg_s2 <= dneg_s1;
			for (int i = 0; i < 3; i++) begin
				sqpp_s2[i][0] <= dpad1[i][MUL_W-1:0] * dpad1[i][MUL_W-1:0];
				sqpp_s2[i][1] <= dpad1[i][MUL_W-1:0] * dpad1[i][PADW-1:MUL_W];
				sqpp_s2[i][2] <= dpad1[i][PADW-1:MUL_W] * dpad1[i][PADW-1:MUL_W];
			end
			npp_s2[0] <= pc_s1[MASS_W-1:0] * mb_s1;
			npp_s2[1] <= pc_s1[2*MASS_W-1:MASS_W] * mb_s1;
		end
	end

	// ---------------------------------------------------------------- s3: squares, mass product
	logic                  v_s3;
	func_t                 func_s3;
	logic [2:0][MW-1:0]    dmag_s3;
	logic [2:0]            dneg_s3;
	logic [SQW-1:0]        sq_s3 [3];
	logic [NUM_W-1:0]      num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			dmag_s3 <= dmag_s2;
			dneg_s3 <= dneg_s2;
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= SQW'((2*PADW)'(sqpp_s2[i][0])
					+ ((2*PADW)'(sqpp_s2[i][1]) << (MUL_W + 1))
					+ ((2*PADW)'(sqpp_s2[i][2]) << PADW));
			num_s3 <= NUM_W'(npp_s2[0]) + (NUM_W'(npp_s2[1]) << MASS_W);
		end
	end

	// ---------------------------------------------------------------- s4: squared distance
	logic  v_s4;
	side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.func <= func_s3;
			side_s4.dmag <= dmag_s3;
			side_s4.dneg <= dneg_s3;
			side_s4.num  <= num_s3;
			side_s4.dsum <= DSW'(sq_s3[0]) + DSW'(sq_s3[1]) + DSW'(sq_s3[2]);
		end
	end

	// ---------------------------------------------------------------- square root, bit per stage
	logic [RW-1:0]   sq_v_s;
	logic [REMW-1:0] sq_rem_s  [RW];
	logic [RW-1:0]   sq_root_s [RW];
	logic [DSW-1:0]  sq_rest_s [RW];
	side_t           sq_side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [REMW-1:0] p_rem;
		logic [RW-1:0]   p_root;
		logic [DSW-1:0]  p_rest;
		logic            p_v;
		side_t           p_side;
		logic [REMW+1:0] sh;
		logic [REMW+1:0] trial;

		if (k == 0) begin : g_first
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rest = side_s4.dsum;
			assign p_v    = v_s4;
			assign p_side = side_s4;
		end else begin : g_next
			assign p_rem  = sq_rem_s[k-1];
			assign p_root = sq_root_s[k-1];
			assign p_rest = sq_rest_s[k-1];
			assign p_v    = sq_v_s[k-1];
			assign p_side = sq_side_s[k-1];
		end

		assign sh    = {p_rem, p_rest[DSW-1 -: 2]};
		assign trial = {{(REMW-RW){1'b0}}, p_root, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k] <= 1'b0;
			else if (en)
				sq_v_s[k] <= p_v;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sh >= trial) begin
					sq_rem_s[k]  <= REMW'(sh - trial);
					sq_root_s[k] <= {p_root[RW-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= sh[REMW-1:0];
					sq_root_s[k] <= {p_root[RW-2:0], 1'b0};
				end
				sq_rest_s[k] <= p_rest << 2;
				sq_side_s[k] <= p_side;
			end
		end
	end

	// ---------------------------------------------------------------- s5: case selection
	logic [RW-1:0]       root_sq;
	side_t               side_sq;
	logic signed [QW-1:0] qd;
	logic                qpos, qneg;
	mode_t               mode_c;

	assign root_sq = sq_root_s[RW-1];
	assign side_sq = sq_side_s[RW-1];
	assign qd      = $signed({{(QW-RW){1'b0}}, root_sq})
		- $signed({{(QW-RAD2_W){1'b0}}, radius_q, 1'b0});
	assign qneg    = qd[QW-1];
	assign qpos    = !qd[QW-1] && (qd != '0);

	always_comb begin
		mode_c = MD_NONE;
		case (side_sq.func)
			FN_PAIR: begin
				if (anti_q) begin
					if (qpos)
						mode_c = MD_QSQ;
					else if (qneg)
						mode_c = MD_CLOSE;
				end else if (side_sq.dsum != '0) begin
					mode_c = MD_SUM;
				end
			end
			FN_REGION: begin
				if (side_sq.dsum != '0)
					mode_c = MD_SUM;
			end
			FN_GRAVITY: begin
				if (root_sq != '0)
					mode_c = MD_GRAV;
			end
			default: mode_c = MD_NONE;
		endcase
	end

	logic          v_s5;
	mode_t         mode_s5;
	logic [RW-1:0] qmag_s5, root_s5;
	side_t         side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= sq_v_s[RW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= mode_c;
			qmag_s5 <= qd[RW-1:0];
			root_s5 <= root_sq;
			side_s5 <= side_sq;
		end
	end

	// ---------------------------------------------------------------- s6/s7: q squared, 100x
	logic [PADW-1:0] qpad;
	assign qpad = {{(PADW-RW){1'b0}}, qmag_s5};

	logic            v_s6;
	mode_t           mode_s6;
	logic [RW-1:0]   root_s6;
	side_t           side_s6;
	logic [PADW-1:0] qpp_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s6   <= mode_s5;
			root_s6   <= root_s5;
			side_s6   <= side_s5;
			qpp_s6[0] <= qpad[MUL_W-1:0] * qpad[MUL_W-1:0];
			qpp_s6[1] <= qpad[MUL_W-1:0] * qpad[PADW-1:MUL_W];
			qpp_s6[2] <= qpad[PADW-1:MUL_W] * qpad[PADW-1:MUL_W];
		end
	end

	logic                v_s7;
	mode_t               mode_s7;
	logic [RW-1:0]       root_s7;
	side_t               side_s7;
	logic [QSW-1:0]      qsq_s7;
	logic [NUM100_W-1:0] num100_s7;
	logic [NUM100_W-1:0] nx;

	assign nx = NUM100_W'(side_s6.num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s7   <= mode_s6;
			root_s7   <= root_s6;
			side_s7   <= side_s6;
			qsq_s7    <= QSW'((2*PADW)'(qpp_s6[0])
				+ ((2*PADW)'(qpp_s6[1]) << (MUL_W + 1))
				+ ((2*PADW)'(qpp_s6[2]) << PADW));
			// 100 = 64 + 32 + 4
			num100_s7 <= (nx << 6) + (nx << 5) + (nx << 2);
		end
	end

	// ---------------------------------------------------------------- s8: denominator, numerator
	logic [DENW-1:0]     den_c;

	always_comb begin
		case (mode_s7)
			MD_SUM:   den_c = DENW'(side_s7.dsum) << FB;
			MD_QSQ:   den_c = DENW'(qsq_s7) << FB;
			MD_CLOSE: den_c = DENW'(1) << (3 * FB);
			MD_GRAV:  den_c = DENW'(root_s7) << (2 * FB);
			default:  den_c = DENW'(1);
		endcase
	end

	logic                v_s8;
	logic                hit_s8;
	logic [2:0]          neg_s8;
	logic [2:0][MW-1:0]  dmag_s8;
	logic [DENW-1:0]     den_s8;
	logic [NUM100_W-1:0] numsel_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8    <= (mode_s7 != MD_NONE);
			neg_s8    <= side_s7.dneg ^ {3{mode_s7 == MD_GRAV}};
			dmag_s8   <= side_s7.dmag;
			den_s8    <= den_c;
			numsel_s8 <= (mode_s7 == MD_CLOSE) ? num100_s7 : NUM100_W'(side_s7.num);
		end
	end

	// ---------------------------------------------------------------- s9-s11: displacement x numerator
	logic [NPADW-1:0] npad;
	logic [PADW-1:0]  dpad8 [3];

	assign npad = {{(NPADW-NUM100_W){1'b0}}, numsel_s8};
	always_comb begin
		for (int i = 0; i < 3; i++)
			dpad8[i] = {{(PADW-MW){1'b0}}, dmag_s8[i]};
	end

	logic            v_s9;
	logic            hit_s9;
	logic [2:0]      neg_s9;
	logic [DENW-1:0] den_s9;
	logic [PADW-1:0] npp_s9 [3][2][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s9 <= hit_s8;
			neg_s9 <= neg_s8;
			den_s9 <= den_s8;
			for (int a = 0; a < 3; a++)
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 4; j++)
						npp_s9[a][i][j] <= dpad8[a][MUL_W*i +: MUL_W]
							* npad[MUL_W*j +: MUL_W];
		end
	end

	logic            v_s10;
	logic            hit_s10;
	logic [2:0]      neg_s10;
	logic [DENW-1:0] den_s10;
	logic [ROWW-1:0] row_s10 [3][2];
	logic [ROWW-1:0] row_c   [3][2];

	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int i = 0; i < 2; i++) begin
				row_c[a][i] = '0;
				for (int j = 0; j < 4; j++)
					row_c[a][i] = row_c[a][i] + (ROWW'(npp_s9[a][i][j]) << (MUL_W * j));
			end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s10 <= hit_s9;
			neg_s10 <= neg_s9;
			den_s10 <= den_s9;
			row_s10 <= row_c;
		end
	end

	logic            v_s11;
	logic            hit_s11;
	logic [2:0]      neg_s11;
	logic [DENW-1:0] den_s11;
	logic [NW-1:0]   n_s11 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s11 <= 1'b0;
		else if (en)
			v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s11 <= hit_s10;
			neg_s11 <= neg_s10;
			den_s11 <= den_s10;
			for (int a = 0; a < 3; a++)
				n_s11[a] <= NW'((ROWW + MUL_W)'(row_s10[a][0])
					+ ((ROWW + MUL_W)'(row_s10[a][1]) << MUL_W));
		end
	end

	// ---------------------------------------------------------------- s12: overflow check
	// quotient fits 48 bits exactly when the numerator's top part is below the divisor
	logic [CMPW-1:0] ntop [3];

	always_comb begin
		for (int a = 0; a < 3; a++)
			ntop[a] = CMPW'(n_s11[a][NW-1:OUT_W]);
	end

	logic              v_s12;
	dv_side_t          dside_s12;
	logic [DENW-1:0]   rem_s12 [3];
	logic [OUT_W-1:0]  w_s12   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s12 <= 1'b0;
		else if (en)
			v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s12.hit <= hit_s11;
			dside_s12.neg <= neg_s11;
			dside_s12.den <= den_s11;
			for (int a = 0; a < 3; a++) begin
				dside_s12.ovf[a] <= ntop[a] >= CMPW'(den_s11);
				rem_s12[a]       <= ntop[a][DENW-1:0];
				w_s12[a]         <= n_s11[a][OUT_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- restoring divider
	// Numerator low bits shift out of the top of w while quotient bits enter at the bottom.
	logic [DIVN-1:0]  dv_v_s;
	dv_side_t         dv_side_s [DIVN];
	logic [DENW-1:0]  dv_rem_s  [DIVN][3];
	logic [OUT_W-1:0] dv_w_s    [DIVN][3];

	for (genvar k = 0; k < DIVN; k++) begin : g_div
		logic     p_v;
		dv_side_t p_side;

		if (k == 0) begin : g_first
			assign p_v    = v_s12;
			assign p_side = dside_s12;
		end else begin : g_next
			assign p_v    = dv_v_s[k-1];
			assign p_side = dv_side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k] <= 1'b0;
			else if (en)
				dv_v_s[k] <= p_v;
		end

		always_ff @(posedge clk) begin
			if (en)
				dv_side_s[k] <= p_side;
		end

		for (genvar a = 0; a < 3; a++) begin : g_ax
			logic [DENW-1:0]  p_rem;
			logic [OUT_W-1:0] p_w;
			logic [DENW:0]    sh;
			logic             take;

			if (k == 0) begin : g_first
				assign p_rem = rem_s12[a];
				assign p_w   = w_s12[a];
			end else begin : g_next
				assign p_rem = dv_rem_s[k-1][a];
				assign p_w   = dv_w_s[k-1][a];
			end

			assign sh   = {p_rem, p_w[OUT_W-1]};
			assign take = sh >= {1'b0, p_side.den};

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k][a] <= take ? DENW'(sh - {1'b0, p_side.den}) : sh[DENW-1:0];
					dv_w_s[k][a]   <= {p_w[OUT_W-2:0], take};
				end
			end
		end
	end

	// ---------------------------------------------------------------- s13: saturate, output
	dv_side_t         fin;
	logic [OUT_W-1:0] lim [3];
	logic [OUT_W-1:0] mag [3];
	logic [OUT_W-1:0] res [3];

	assign fin = dv_side_s[DIVN-1];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lim[a] = fin.neg[a] ? SAT_NEG : SAT_POS;
			mag[a] = (fin.ovf[a] || (dv_w_s[DIVN-1][a] > lim[a])) ? lim[a] : dv_w_s[DIVN-1][a];
			if (!fin.hit)
				res[a] = '0;
			else if (fin.neg[a])
				res[a] = ~mag[a] + OUT_W'(1);
			else
				res[a] = mag[a];
		end
	end

	logic             v_s13;
	logic [OUT_W-1:0] fx_s13, fy_s13, fz_s13;
	logic             hit_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s13 <= 1'b0;
		else if (en)
			v_s13 <= dv_v_s[DIVN-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s13  <= res[0];
			fy_s13  <= res[1];
			fz_s13  <= res[2];
			hit_s13 <= fin.hit;
		end
	end

	assign out_valid = v_s13;
	assign force_x   = $signed(fx_s13);
	assign force_y   = $signed(fy_s13);
	assign force_z   = $signed(fz_s13);
	assign applied   = hit_s13;

	// ---------------------------------------------------------------- checks
	a_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !applied |-> force_x == '0 && force_y == '0 && force_z == '0)
		else $error("force without an applied case");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[RW-1] |-> sq_rem_s[RW-1] <= REMW'({sq_root_s[RW-1], 1'b0}))
		else $error("square root remainder out of range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DIVN-1] |->
			(dv_side_s[DIVN-1].ovf[0] || dv_rem_s[DIVN-1][0] < dv_side_s[DIVN-1].den) &&
			(dv_side_s[DIVN-1].ovf[1] || dv_rem_s[DIVN-1][1] < dv_side_s[DIVN-1].den) &&
			(dv_side_s[DIVN-1].ovf[2] || dv_rem_s[DIVN-1][2] < dv_side_s[DIVN-1].den))
		else $error("divider remainder not below divisor");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && in_stall |=> v_s1 && $stable(pc_s1))
		else $error("first stage lost its word during a stall");

endmodule
`default_nettype wire

/* test/lrf3d_force_checker.sv */
// Checker for the repulsion unit: watches both channels, predicts each force word and compares.
`timescale 1ns / 1ps
module lrf3d_force_checker
	import lrf3d_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  wire  [1:0]          func,
	input  wire  signed [31:0]  a_x,
	input  wire  signed [31:0]  a_y,
	input  wire  signed [31:0]  a_z,
	input  wire  [MASS_W-1:0]   a_mass,
	input  wire  signed [31:0]  b_x,
	input  wire  signed [31:0]  b_y,
	input  wire  signed [31:0]  b_z,
	input  wire  [MASS_W-1:0]   b_mass,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  wire  signed [47:0]  force_x,
	input  wire  signed [47:0]  force_y,
	input  wire  signed [47:0]  force_z,
	input  wire                 applied,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]    cfg_data,
	output int                  failures,
	output int                  pending
);

	typedef logic [255:0] wide_t;
	typedef struct {
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		logic        app;
	} force_t;

	localparam wide_t ONE_Q = wide_t'(1) << FRAC_BITS_DEF;

	logic [CFG_W-1:0] coef_r, radius_r, grav_r;
	logic             anti_r;
	force_t           force_due[$];
	int               fail_cnt;

	function automatic logic [63:0] root_floor(input wide_t v);
		logic [63:0] r, t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (wide_t'(t) * wide_t'(t) <= v)
				r = t;
		end
		return r;
	endfunction

	// |d| * num / den, sign applied, clipped to 48 bits
	function automatic logic [47:0] scale_sat(input longint d, input wide_t num,
			input wide_t den, input bit negate);
		logic [63:0] mag;
		wide_t       q;
		bit          neg;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		q   = wide_t'(mag) * num / den;
		neg = (d < 0) ^ negate;
		if (neg) begin
			if (q > (wide_t'(1) << 47))
				q = wide_t'(1) << 47;
			return 48'(-q[47:0]);
		end
		if (q > (wide_t'(1) << 47) - 1)
			q = (wide_t'(1) << 47) - 1;
		return q[47:0];
	endfunction

	function automatic force_t repulsion_force(input logic [1:0] fn,
			input logic signed [31:0] ax, ay, az, input logic [31:0] am,
			input logic signed [31:0] bx, by, bz, input logic [31:0] bm);
		longint      disp[3];
		longint      qa;
		logic [63:0] m, qr;
		wide_t       sum, num, den;
		bit          neg, hit;
		force_t      f;
		func_t       op;
		op = func_t'(fn);
		disp[0] = (op == FN_GRAVITY) ? longint'(ax) : longint'(ax) - longint'(bx);
		disp[1] = (op == FN_GRAVITY) ? longint'(ay) : longint'(ay) - longint'(by);
		disp[2] = (op == FN_GRAVITY) ? longint'(az) : longint'(az) - longint'(bz);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m   = (disp[i] < 0) ? 64'(-disp[i]) : 64'(disp[i]);
			sum = sum + wide_t'(m) * wide_t'(m);
		end
		num = wide_t'(coef_r) * wide_t'(am) * wide_t'(bm);
		den = 1;
		neg = 0;
		hit = 0;
		if (op == FN_PAIR && anti_r) begin
			qa = longint'(root_floor(sum)) - 2 * longint'({32'd0, radius_r});
			if (qa > 0) begin
				den = ONE_Q * wide_t'(qa) * wide_t'(qa);
				hit = 1;
			end else if (qa < 0) begin
				// overlapping nodes: flat 100x push
				num = num * 100;
				den = ONE_Q * ONE_Q * ONE_Q;
				hit = 1;
			end
		end else if (op == FN_PAIR || op == FN_REGION) begin
			if (sum != 0) begin
				den = ONE_Q * sum;
				hit = 1;
			end
		end else if (op == FN_GRAVITY) begin
			qr = root_floor(sum);
			if (qr != 0) begin
				num = wide_t'(coef_r) * wide_t'(am) * wide_t'(grav_r);
				den = ONE_Q * ONE_Q * wide_t'(qr);
				neg = 1;
				hit = 1;
			end
		end
		f.fx  = hit ? scale_sat(disp[0], num, den, neg) : '0;
		f.fy  = hit ? scale_sat(disp[1], num, den, neg) : '0;
		f.fz  = hit ? scale_sat(disp[2], num, den, neg) : '0;
		f.app = hit;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		force_t exp_f;
		if (!arst_n) begin
			coef_r   = COEF_RST;
			radius_r = RADIUS_RST;
			grav_r   = GRAVITY_RST;
			anti_r   = 1'b0;
			fail_cnt = 0;
			force_due.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (force_due.size() == 0) begin
					$display("%0t: unexpected word fx=%h fy=%h fz=%h app=%b", $time,
						force_x, force_y, force_z, applied);
					fail_cnt++;
				end else begin
					exp_f = force_due.pop_front();
					if (force_x !== exp_f.fx || force_y !== exp_f.fy ||
							force_z !== exp_f.fz || applied !== exp_f.app) begin
						$display("%0t: mismatch exp fx=%h fy=%h fz=%h app=%b", $time,
							exp_f.fx, exp_f.fy, exp_f.fz, exp_f.app);
						$display("%0t:          got fx=%h fy=%h fz=%h app=%b", $time,
							force_x, force_y, force_z, applied);
						fail_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				force_due.push_back(repulsion_force(func, a_x, a_y, a_z, a_mass,
					b_x, b_y, b_z, b_mass));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COEF:    coef_r   = cfg_data;
					REG_ANTI:    anti_r   = cfg_data[0];
					REG_RADIUS:  radius_r = cfg_data;
					REG_GRAVITY: grav_r   = cfg_data;
					default: ;
				endcase
			end
			failures <= fail_cnt;
			pending  <= force_due.size();
		end
	end

endmodule

/* test/tb_top.sv */
// Testbench top: clock, reset, stimulus, result-side stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
	import lrf3d_pkg::*;

	localparam int PHASES     = 6;
	localparam int RAND_ITEMS = 275;  // per phase, ~1650 overall
	localparam int PIPE_PAD   = 120;  // beyond the pipe depth
	localparam int IDLE_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           func;
	logic signed [31:0]   a_x, a_y, a_z, b_x, b_y, b_z;
	logic [MASS_W-1:0]    a_mass, b_mass;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [47:0]   force_x, force_y, force_z;
	logic                 applied;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   failures;
	int                   pending;
	int                   idle_cycles;
	int                   stall_left;

	layout_repulsion_force_3d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_mass(a_mass),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_mass(b_mass),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z), .applied(applied),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lrf3d_force_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_mass(a_mass),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_mass(b_mass),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z), .applied(applied),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
	endfunction

	// result-side back-pressure in bursts, with quiet stretches between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 9))
				0:       begin out_stall <= 1'b1; stall_left <= $urandom_range(20, 70); end
				1, 2, 3: begin out_stall <= 1'b1; stall_left <= $urandom_range(0, 5); end
				4:       begin out_stall <= 1'b0; stall_left <= $urandom_range(100, 300); end
				default: begin out_stall <= 1'b0; stall_left <= $urandom_range(0, 8); end
			endcase
		end
	end

	// watchdog: any accepted word or register write resets the count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// one word onto the input channel; valid stays high into a gapless next word
	task automatic send_word(input func_t fn,
			input logic [31:0] ax, ay, az, am, bx, by, bz, bm);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		func   <= fn;
		a_x    <= ax; a_y <= ay; a_z <= az; a_mass <= am;
		b_x    <= bx; b_y <= by; b_z <= bz; b_mass <= bm;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// valid stays high between back-to-back writes; set_regs drops it at the end
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// pipe fully drained before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_PAD) @(posedge clk);
	endtask

	task automatic set_regs(input int ph);
		case (ph)
			0: begin
				write_reg(REG_COEF, COEF_RST);     write_reg(REG_ANTI, 32'd0);
				write_reg(REG_RADIUS, RADIUS_RST); write_reg(REG_GRAVITY, GRAVITY_RST);
			end
			1: begin
				write_reg(REG_COEF, 32'hFFFF_FFFF); write_reg(REG_ANTI, 32'd1);
				write_reg(REG_RADIUS, 32'h0001_0000); write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
			end
			2: begin
				write_reg(REG_COEF, 32'd0);   write_reg(REG_ANTI, 32'hFFFF_FFFE);
				write_reg(REG_RADIUS, 32'd0); write_reg(REG_GRAVITY, 32'd0);
			end
			3: begin
				write_reg(REG_COEF, $urandom); write_reg(REG_ANTI, 32'd1);
				write_reg(REG_RADIUS, 32'd0);  write_reg(REG_GRAVITY, $urandom);
			end
			4: begin
				write_reg(REG_COEF, 32'h0001_0000); write_reg(REG_ANTI, 32'd1);
				write_reg(REG_RADIUS, 32'hFFFF_FFFF); write_reg(REG_GRAVITY, 32'd1);
			end
			default: begin
				write_reg(REG_COEF, $urandom >> $urandom_range(0, 16));
				write_reg(REG_ANTI, $urandom);
				write_reg(REG_RADIUS, $urandom >> $urandom_range(8, 24));
				write_reg(REG_GRAVITY, $urandom >> $urandom_range(0, 16));
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// corners: zero distance, overlap, saturation both ways, unused selector
	task automatic directed_words();
		send_word(FN_PAIR, 32'h10000, 32'h20000, 32'h30000, 32'h10000,
			32'h10000, 32'h20000, 32'h30000, 32'h10000);
		send_word(FN_PAIR, 32'h30000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
		send_word(FN_PAIR, 32'h100, 32'h80, 0, 32'h10000, 0, 0, 0, 32'h20000);
		send_word(FN_PAIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(FN_PAIR, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF);
		send_word(FN_PAIR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF);
		send_word(FN_PAIR, 32'h50000, 32'h50000, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_word(FN_REGION, 32'h8000_0000, 0, 0, 32'h10000, 32'h7FFF_FFFF, 0, 0, 32'h10000);
		send_word(FN_REGION, 5, 5, 5, 32'h10000, 5, 5, 5, 32'h10000);
		send_word(FN_REGION, 32'hFFFF_0000, 32'h2_0000, 0, 32'h30000, 0, 0, 0, 32'h40000);
		send_word(FN_GRAVITY, 0, 0, 0, 32'h10000, 32'h1234, 0, 0, 32'h10000);
		send_word(FN_GRAVITY, 32'h30000, 32'hFFFC_0000, 0, 32'h20000, 0, 0, 0, 0);
		send_word(FN_GRAVITY, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send_word(FN_GRAVITY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
			0, 0, 0, 32'hFFFF_FFFF);
		send_word(FN_NONE, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
		send_word(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// B near A at a random scale, so both sides of the overlap threshold get hit
	function automatic logic [31:0] near(input logic [31:0] p);
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		if ($urandom_range(0, 15) == 0)
			return p;
		return p - ($signed($urandom) >>> $urandom_range(0, 31));
	endfunction

	task automatic random_word();
		logic [31:0] ax, ay, az;
		func_t       fn;
		fn = ($urandom_range(0, 19) == 0) ? FN_NONE : func_t'($urandom_range(0, 2));
		ax = $signed($urandom) >>> $urandom_range(0, 31);
		ay = $signed($urandom) >>> $urandom_range(0, 31);
		az = $signed($urandom) >>> $urandom_range(0, 31);
		send_word(fn, ax, ay, az, $urandom >> $urandom_range(0, 31),
			near(ax), near(ay), near(az), $urandom >> $urandom_range(0, 31));
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FN_PAIR;
		a_x = 0; a_y = 0; a_z = 0; a_mass = 0;
		b_x = 0; b_y = 0; b_z = 0; b_mass = 0;
		cfg_valid = 1'b0;
		cfg_index = REG_COEF;
		cfg_data  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0)
				drain();
			set_regs(ph);
			if (ph < 2)
				directed_words();
			for (int n = 0; n < RAND_ITEMS; n++)
				random_word();
		end
		drain();

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
